// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/bol_pkg.sv =====
package bol_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SUM_W = IDX_W + 1;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   localparam logic [2:0] OP_INS_FRONT = 3'd0;
   localparam logic [2:0] OP_INS_END   = 3'd1;
   localparam logic [2:0] OP_READ_ALL  = 3'd2;
   localparam logic [2:0] OP_COUNT     = 3'd3;
   localparam logic [2:0] OP_DEL_FIRST = 3'd4;
   localparam logic [2:0] OP_DEL_LAST  = 3'd5;
   localparam logic [2:0] OP_DEL_POS   = 3'd6;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] value;
      logic [7:0]         position;
   } req_type;

   typedef struct packed {
      logic signed [31:0] element;
      logic               element_valid;
      logic [4:0]         length;
      logic [1:0]         status;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic               en;
      idx_type            off;
      logic signed [31:0] data;
   } wr_type;

   // Adds an offset to a ring position and wraps at the list capacity.
   function automatic idx_type wrap_add(idx_type base, idx_type off);
      logic [SUM_W-1:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= SUM_W'(CAPACITY)) begin
         sum = sum - SUM_W'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

// ===== hdl/bol_store.sv =====
module bol_store import bol_pkg::*; (
   input  logic               clock,
   input  idx_type            head,
   input  idx_type            rd_off,
   input  wr_type             wr,
   output logic signed [31:0] rd_data
);

   logic signed [31:0] mem [CAPACITY];
   idx_type            rd_addr;
   idx_type            wr_addr;

   assign rd_addr = wrap_add(head, rd_off);
   assign wr_addr = wrap_add(head, wr.off);

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_addr] <= wr.data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hdl/bounded_ordered_list_unit.sv =====
// Every command but a read-out of a non-empty list answers in the cycle after its acceptance.
// A read-out passes its first element through the memory read register and the response
// register, then one element per cycle while responses are taken, set by the single read port
// of the entry memory. A delete inside the list reads, then writes back, each later element.
// Synchronous active-high reset empties the list; the entry memory itself is not cleared.
module bounded_ordered_list_unit import bol_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_READ  = 2'd1;
   localparam logic [1:0] S_SH_RD = 2'd2;
   localparam logic [1:0] S_SH_WR = 2'd3;

   logic [1:0]         state_ff, state_in;
   cnt_type            count_ff, count_in;
   idx_type            head_ff, head_in;
   idx_type            off_ff, off_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   idx_type            rd_off;
   wr_type             wr;
   logic signed [31:0] rd_data;
   logic               slot_free;
   logic               accept;
   logic               single;
   logic [1:0]         status;
   logic               full;
   logic               empty;
   idx_type            last_off;
   idx_type            pos_off;

   bol_store u_store (
      .clock   (clock),
      .head    (head_ff),
      .rd_off  (rd_off),
      .wr      (wr),
      .rd_data (rd_data)
   );

   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign empty    = (count_ff == '0);
   assign last_off = IDX_W'(count_ff - CNT_W'(1));
   assign pos_off  = (32'(req_data.position) >= 32'(last_off)) ? last_off
                                                               : IDX_W'(req_data.position);

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      off_in       = off_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      rd_off       = off_ff;
      wr           = '0;
      single       = 1'b0;
      status       = ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               single = 1'b1;
               case (req_data.opcode)
                  OP_INS_FRONT: begin
                     if (full) begin
                        status = ST_FULL;
                     end else begin
                        wr.en    = 1'b1;
                        wr.off   = IDX_W'(CAPACITY - 1);
                        wr.data  = req_data.value;
                        head_in  = wrap_add(head_ff, IDX_W'(CAPACITY - 1));
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_INS_END: begin
                     if (full) begin
                        status = ST_FULL;
                     end else begin
                        wr.en    = 1'b1;
                        wr.off   = IDX_W'(count_ff);
                        wr.data  = req_data.value;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_READ_ALL: begin
                     if (!empty) begin
                        single   = 1'b0;
                        rd_off   = '0;
                        off_in   = '0;
                        state_in = S_READ;
                     end
                  end
                  OP_DEL_FIRST: begin
                     if (empty) begin
                        status = ST_EMPTY;
                     end else begin
                        head_in  = wrap_add(head_ff, IDX_W'(1));
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  OP_DEL_LAST: begin
                     if (empty) begin
                        status = ST_EMPTY;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  OP_DEL_POS: begin
                     if (empty) begin
                        status = ST_EMPTY;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                        if (pos_off == '0) begin
                           head_in = wrap_add(head_ff, IDX_W'(1));
                        end else if (pos_off != last_off) begin
                           off_in   = pos_off;
                           state_in = S_SH_RD;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            if (slot_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.element       = rd_data;
               rsp_in.element_valid = 1'b1;
               rsp_in.length        = 5'(count_ff);
               rsp_in.status        = ST_OK;
               rsp_in.last          = (off_ff == last_off);
               if (off_ff == last_off) begin
                  state_in = S_IDLE;
               end else begin
                  off_in = off_ff + IDX_W'(1);
                  rd_off = off_ff + IDX_W'(1);
               end
            end
         end
         S_SH_RD: begin
            rd_off   = off_ff + IDX_W'(1);
            state_in = S_SH_WR;
         end
         S_SH_WR: begin
            wr.en   = 1'b1;
            wr.off  = off_ff;
            wr.data = rd_data;
            if (off_ff == last_off) begin
               state_in = S_IDLE;
            end else begin
               off_in   = off_ff + IDX_W'(1);
               state_in = S_SH_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (single) begin
         rsp_valid_in         = 1'b1;
         rsp_in.element       = '0;
         rsp_in.element_valid = 1'b0;
         rsp_in.length        = 5'(count_in);
         rsp_in.status        = status;
         rsp_in.last          = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         off_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         off_ff       <= off_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hdl/bol_checker.sv =====
`include "assert_macros.svh"

module bol_checker import bol_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   logic unused_in;

   assign unused_in = req_valid ^ (^req_data);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   `ASSERT_NOW(a_plain_result, clock, reset, rsp_valid && !rsp_data.element_valid, rsp_data.last && (rsp_data.element == '0))

   `ASSERT_NOW(a_error_no_element, clock, reset, rsp_valid && (rsp_data.status != ST_OK), !rsp_data.element_valid)

   `ASSERT_NOW(a_busy_in_readout, clock, reset, rsp_valid && rsp_data.element_valid && !rsp_data.last, !req_ready)

   `ASSERT_NEXT(a_readout_streams, clock, reset, rsp_valid && rsp_ready && rsp_data.element_valid && !rsp_data.last, rsp_valid && rsp_data.element_valid)

endmodule

bind bounded_ordered_list_unit bol_checker u_bol_checker (.*);
